/* rtl/wbfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbfs_pkg
// Shared types, codes and defaults for the whitelisted bitmap flag store.
// ----------------------------------------------------------------------------
package wbfs_pkg;

  localparam int DEF_TABLE_DEPTH  = 256;
  localparam int DEF_BITMAP_BYTES = 128;
  localparam int BITS_PER_BYTE    = 8;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 8;
  localparam int ORDINAL_W   = 16;
  localparam int COUNT_W     = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_READS_ENABLED  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITES_ENABLED = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [INDEX_W-1:0]   entry_index;
    logic [ORDINAL_W-1:0] ordinal;
    logic                 bit_value;
  } request_t;

  typedef struct packed {
    logic result_bit;
    logic found;
    logic in_range;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_SEARCH,
    ST_CHECK,
    ST_BITRD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic issue;
    logic step;
    logic check;
    logic bit_access;
  } dp_cmd_t;

  typedef struct packed {
    logic                clear_last;
    logic [ACTION_W-1:0] req_action;
    logic                range_open;
    logic                step_open;
    logic                access_ok;
  } dp_status_t;

endpackage

/* rtl/wbfs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbfs_datapath
// Configuration registers, ordinal table, flag bitmap, binary search
// bounds and result registers.
// ----------------------------------------------------------------------------
module wbfs_datapath #(
  parameter int TABLE_DEPTH  = wbfs_pkg::DEF_TABLE_DEPTH,
  parameter int BITMAP_BYTES = wbfs_pkg::DEF_BITMAP_BYTES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wbfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wbfs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wbfs_pkg::request_t                 request,
  input  wbfs_pkg::dp_cmd_t                  cmd,
  output wbfs_pkg::dp_status_t               status,
  output wbfs_pkg::result_t                  result
);
  import wbfs_pkg::*;

  localparam int TA_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int BA_W      = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int FLAG_BITS = BITMAP_BYTES * BITS_PER_BYTE;
  localparam logic [BA_W-1:0] CLR_LAST = BA_W'(BITMAP_BYTES - 1);

  // Configuration registers.
  logic [COUNT_W-1:0] active_count;
  logic               reads_enabled;
  logic               writes_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count   <= '0;
      reads_enabled  <= 1'b0;
      writes_enabled <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_COUNT:   active_count   <= cfg_data;
        REG_READS_ENABLED:  reads_enabled  <= cfg_data[0];
        REG_WRITES_ENABLED: writes_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Search span saturates at the table depth.
  logic [CNT_W-1:0] count_sat;
  assign count_sat = (32'(active_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(active_count);

  request_t         req;
  logic [CNT_W-1:0] lo, hi, mid;
  logic [CNT_W-1:0] lo_next, hi_next, mid_next, mid_cur, tbl_addr_full;
  logic             go_right;
  logic [ORDINAL_W-1:0] tbl_rdata;
  logic [7:0]       bm_rdata;
  logic [7:0]       bm_new;
  logic [BA_W-1:0]  clr_addr;
  logic [BA_W-1:0]  byte_addr;
  logic [31:0]      byte_full;
  logic [2:0]       bit_sel;
  logic             found_now;
  logic             key_range;
  logic [31:0]      load_idx;

  logic [ORDINAL_W-1:0] ordinal_table [TABLE_DEPTH];
  logic [7:0]           flag_bitmap   [BITMAP_BYTES];

  assign mid_cur  = lo + ((hi - lo) >> 1);
  assign go_right = tbl_rdata < req.ordinal;
  assign lo_next  = go_right ? mid + CNT_W'(1) : lo;
  assign hi_next  = go_right ? hi : mid;
  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);

  // A step reads the next probe, or the final lower-bound entry once closed.
  always_comb begin
    priority if (cmd.step) begin
      tbl_addr_full = (lo_next < hi_next) ? mid_next : lo_next;
    end else if (lo < hi) begin
      tbl_addr_full = mid_cur;
    end else begin
      tbl_addr_full = lo;
    end
  end

  assign load_idx  = 32'(request.entry_index);
  assign key_range = 32'(request.ordinal) < FLAG_BITS;
  assign found_now = (lo < count_sat) && (tbl_rdata == req.ordinal);
  assign byte_full = 32'(req.ordinal) >> 3;
  assign byte_addr = byte_full[BA_W-1:0];
  assign bit_sel   = req.ordinal[2:0];

  always_comb begin
    bm_new          = bm_rdata;
    bm_new[bit_sel] = req.bit_value;
  end

  // Ordinal table: loaded at the accepting edge, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.latch && request.action == ACT_LOAD && load_idx < TABLE_DEPTH) begin
      ordinal_table[load_idx[TA_W-1:0]] <= request.ordinal;
    end
    tbl_rdata <= ordinal_table[tbl_addr_full[TA_W-1:0]];
  end

  // Flag bitmap: cleared by a sweep after reset, then read-modify-write.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      flag_bitmap[clr_addr] <= '0;
    end else if (cmd.bit_access && req.action == ACT_WRITE) begin
      flag_bitmap[byte_addr] <= bm_new;
    end
    bm_rdata <= flag_bitmap[byte_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + BA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req               <= request;
      lo                <= '0;
      hi                <= count_sat;
      result.result_bit <= (request.action == ACT_LOAD);
      result.found      <= 1'b0;
      result.in_range   <= (request.action == ACT_READ || request.action == ACT_WRITE)
                           && key_range;
    end
    if (cmd.issue) begin
      mid <= mid_cur;
    end
    if (cmd.step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
    if (cmd.check) begin
      result.found <= found_now;
    end
    if (cmd.bit_access) begin
      result.result_bit <= (req.action == ACT_READ) ? bm_rdata[bit_sel] : 1'b1;
    end
  end

  assign status.clear_last = (clr_addr == CLR_LAST);
  assign status.req_action = request.action;
  assign status.range_open = lo < hi;
  assign status.step_open  = lo_next < hi_next;
  assign status.access_ok  = found_now && result.in_range &&
                             ((req.action == ACT_READ && reads_enabled) ||
                              (req.action == ACT_WRITE && writes_enabled));

  a_step_open: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (lo < hi))
    else $error("search step taken on a closed interval");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.check |-> (lo <= hi) && (hi <= count_sat))
    else $error("search bounds left the table span");

  a_bit_after_check: assert property (@(posedge clk) disable iff (rst)
    cmd.check && status.access_ok |=> cmd.bit_access)
    else $error("allowed access did not reach the bitmap");

endmodule

/* rtl/wbfs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbfs_ctrl
// Sequencer for bitmap clearing, table loads, search and flag access.
// ----------------------------------------------------------------------------
module wbfs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  wbfs_pkg::dp_status_t status,
  output wbfs_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import wbfs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (status.req_action == ACT_READ || status.req_action == ACT_WRITE) begin
            state_next = ST_ISSUE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ISSUE:  state_next = status.range_open ? ST_SEARCH : ST_CHECK;
      ST_SEARCH: state_next = status.step_open ? ST_SEARCH : ST_CHECK;
      ST_CHECK:  state_next = status.access_ok ? ST_BITRD : ST_DONE;
      ST_BITRD:  state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.clear      = (state == ST_CLEAR);
    cmd.latch      = (state == ST_IDLE) && start;
    cmd.issue      = (state == ST_ISSUE);
    cmd.step       = (state == ST_SEARCH);
    cmd.check      = (state == ST_CHECK);
    cmd.bit_access = (state == ST_BITRD);
    busy           = (state != ST_IDLE);
    done           = (state == ST_DONE);
  end

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe not followed by idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_bitrd_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BITRD) |-> ($past(state) == ST_CHECK))
    else $error("bitmap access without a preceding check");

endmodule

/* rtl/whitelisted_bitmap_flag_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whitelisted_bitmap_flag_store
// Flag bitmap guarded by a sorted whitelist table of assigned ordinals.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer happens at a clock edge with start high and busy low.
//   Exactly one result follows, shown on result for the single cycle in
//   which done is high; the receiver cannot stall it, so it must take it.
//   Configuration writes use cfg_we, cfg_index and cfg_data and should be
//   issued while busy is low and no result is pending.
// Operation:
//   A load or an unused action code strobes done in the cycle after the
//   transfer. A read or write passes through issue, one search step per
//   binary search probe, check, a bitmap access if allowed, and done.
//   The probes number at most ceil(log2(count + 1)) (9 for 256 entries).
//   The search issues one table memory read per cycle; the bitmap byte is
//   read through a registered port and, for a write, written back modified.
// Reset:
//   rst is synchronous. After it the block sweeps the bitmap to zero, one
//   byte a cycle, busy high until all BITMAP_BYTES (128 by default) are clear.
// ----------------------------------------------------------------------------
module whitelisted_bitmap_flag_store #(
  parameter int TABLE_DEPTH  = wbfs_pkg::DEF_TABLE_DEPTH,
  parameter int BITMAP_BYTES = wbfs_pkg::DEF_BITMAP_BYTES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  wbfs_pkg::request_t               request,
  output logic                             busy,
  output logic                             done,
  output wbfs_pkg::result_t                result,
  input  logic                             cfg_we,
  input  logic [wbfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wbfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wbfs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  wbfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  wbfs_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
